// ===== hdl/sgth_pkg.sv =====
// Shared types, constants and field layouts for the serial gateway toggle handshake block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package sgth_pkg;

    // Largest number of bytes fetched for one send transaction.
    localparam int unsigned MAX_TX_BYTES = 22;
    localparam int unsigned TX_SIZE_W    = 5;

    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 56;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HANDSHAKE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BAUD      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FRAME     = 2'd2;

    localparam logic       RST_WANT_HANDSHAKE = 1'b0;
    localparam logic [3:0] RST_WANT_BAUD      = 4'd6;
    localparam logic [3:0] RST_WANT_FRAME     = 4'd3;

    // Parameter write outcome codes from the terminal.
    localparam logic [1:0] WRES_SUCCESS = 2'd1;
    localparam logic [1:0] WRES_ERROR   = 2'd2;

    // Parameter write targets.
    localparam logic [1:0] TGT_HANDSHAKE = 2'd0;
    localparam logic [1:0] TGT_BAUD      = 2'd1;
    localparam logic [1:0] TGT_FRAME     = 2'd2;

    localparam logic [7:0]  RST_CUR_HANDSHAKE = 8'hff;
    localparam logic [15:0] CTRL_INIT_REQ     = 16'h0004;
    localparam logic [15:0] CTRL_CLEAR        = 16'h0000;

    typedef struct packed {
        logic       want_handshake;
        logic [3:0] want_baud_code;
        logic [3:0] want_frame_code;
    } cfg_t;

    typedef struct packed {
        logic       tx_ack_bit;
        logic       rx_req_bit;
        logic       init_ack_bit;
        logic [7:0] rx_byte_count;
        logic [7:0] send_available;
        logic [1:0] write_result;
    } in_item_t;

    typedef struct packed {
        logic [15:0]          control_word;
        logic [TX_SIZE_W-1:0] tx_copy_count;
        logic [TX_SIZE_W-1:0] send_taken;
        logic                 rx_deliver;
        logic [7:0]           rx_deliver_count;
        logic                 param_write;
        logic [1:0]           param_target;
        logic [7:0]           param_value;
        logic [2:0]           port_phase;
        logic                 setup_failed;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/serial_gateway_toggle_handshake.sv =====
// Top level of the serial gateway toggle handshake block.
// Depends on sgth_pkg, sgth_cfg_regs, sgth_in_stage, sgth_core and sgth_out_stage.
//
// Each s_ transaction carries one process-data cycle of a terminal port. s_tdata,
// from bit 0 up: tx_ack_bit, rx_req_bit, init_ack_bit, rx_byte_count[7:0],
// send_available[7:0], write_result[1:0], then zero fill. Each m_ transaction gives
// the result of one such cycle. m_tdata, from bit 0 up: control_word[15:0],
// tx_copy_count[4:0], send_taken[4:0], rx_deliver, rx_deliver_count[7:0],
// param_write, param_target[1:0], param_value[7:0], port_phase[2:0], setup_failed,
// then zero fill.
// The cfg_ channel writes want_handshake (index 0), want_baud_code (1) and
// want_frame_code (2); it is always ready, and writes to other indexes are dropped.
// Write it only while no transaction is in flight.
// A result is computed combinationally from the item held in the input register and
// is loaded into the result register whenever that register is free. Throughput is
// one transaction per cycle while the receiver does not stall; the phase machine
// updates as each result is loaded.
// When the receiver stalls, the result register holds and the input register takes
// one more transaction, after which s_tready drops until m_tready returns.
// Reset clears both registers, puts the port in init request, and loads the
// default configuration (no handshake, baud code 6, frame code 3).
`default_nettype none

module serial_gateway_toggle_handshake (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // s_tdata, low bit up: tx_ack_bit, rx_req_bit, init_ack_bit, rx_byte_count,
    // send_available, write_result.
    input  wire logic [sgth_pkg::S_TDATA_W-1:0]  s_tdata,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata, low bit up: control_word, tx_copy_count, send_taken, rx_deliver,
    // rx_deliver_count, param_write, param_target, param_value, port_phase,
    // setup_failed.
    output      logic [sgth_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [sgth_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sgth_pkg::CFG_DATA_W-1:0] cfg_data
);

    sgth_pkg::cfg_t     cfg;
    sgth_pkg::in_item_t item;
    sgth_pkg::result_t  result;
    logic               item_valid;
    logic               out_free;
    logic               advance;

    assign advance = item_valid && out_free;

    sgth_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sgth_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    sgth_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg),
        .item    (item),
        .result  (result)
    );

    sgth_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== hdl/sgth_cfg_regs.sv =====
// Configuration registers of the serial gateway toggle handshake block.
// Depends on sgth_pkg for the register indexes and reset values.
`default_nettype none

module sgth_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [sgth_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sgth_pkg::CFG_DATA_W-1:0] cfg_data,
    output      sgth_pkg::cfg_t                  cfg
);

    sgth_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Writes to an index beyond the register list are taken and dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.want_handshake  <= sgth_pkg::RST_WANT_HANDSHAKE;
            cfg_reg.want_baud_code  <= sgth_pkg::RST_WANT_BAUD;
            cfg_reg.want_frame_code <= sgth_pkg::RST_WANT_FRAME;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sgth_pkg::CFG_IDX_HANDSHAKE: cfg_reg.want_handshake  <= cfg_data[0];
                sgth_pkg::CFG_IDX_BAUD:      cfg_reg.want_baud_code  <= cfg_data;
                sgth_pkg::CFG_IDX_FRAME:     cfg_reg.want_frame_code <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sgth_in_stage.sv =====
// Input register of the serial gateway toggle handshake block: unpacks s_tdata into an item.
// Depends on sgth_pkg for the item type and the tdata width.
`default_nettype none

module sgth_in_stage (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [sgth_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           advance,
    output      logic                           item_valid,
    output      sgth_pkg::in_item_t             item
);

    logic               valid_reg;
    sgth_pkg::in_item_t item_reg;

    // A new transaction is taken when the register is empty or drains this cycle.
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.tx_ack_bit     <= s_tdata[0];
            item_reg.rx_req_bit     <= s_tdata[1];
            item_reg.init_ack_bit   <= s_tdata[2];
            item_reg.rx_byte_count  <= s_tdata[10:3];
            item_reg.send_available <= s_tdata[18:11];
            item_reg.write_result   <= s_tdata[20:19];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sgth_core.sv =====
// Per-port phase machine and toggle exchange of the serial gateway toggle handshake block.
// Depends on sgth_pkg; computes one result from the held item and updates the port state.
`default_nettype none

module sgth_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               advance,
    input  wire sgth_pkg::cfg_t     cfg,
    input  wire sgth_pkg::in_item_t item,
    output      sgth_pkg::result_t  result
);

    typedef enum logic [2:0] {
        PH_INIT_REQ  = 3'd0,
        PH_INIT_WAIT = 3'd1,
        PH_READY     = 3'd2,
        PH_WR_HS     = 3'd3,
        PH_WR_BAUD   = 3'd4,
        PH_WR_FRAME  = 3'd5
    } phase_t;

    localparam int unsigned TXW = sgth_pkg::TX_SIZE_W;
    localparam logic [7:0] MAX_TX = 8'(sgth_pkg::MAX_TX_BYTES);

    phase_t         phase_reg, phase_next;
    logic           tx_req_toggle_reg, tx_req_toggle_next;
    logic           tx_ack_seen_reg, tx_ack_seen_next;
    logic           rx_req_seen_reg, rx_req_seen_next;
    logic           rx_ack_toggle_reg, rx_ack_toggle_next;
    logic [15:0]    control_reg, control_next;
    logic [TXW-1:0] tx_size_reg, tx_size_next;
    logic [7:0]     cur_handshake_reg, cur_handshake_next;
    logic [7:0]     cur_baud_reg, cur_baud_next;
    logic [7:0]     cur_frame_reg, cur_frame_next;
    logic           error_flag_reg, error_flag_next;

    logic [7:0]     want_hs_ext, want_baud_ext, want_frame_ext;
    logic [TXW-1:0] fetch_size;
    logic [TXW-1:0] taken;
    logic           deliver;
    logic [7:0]     deliver_cnt;
    logic           pwrite;
    logic [1:0]     ptarget;
    logic [7:0]     pvalue;
    logic           wr_success, wr_error;

    assign want_hs_ext    = {7'd0, cfg.want_handshake};
    assign want_baud_ext  = {4'd0, cfg.want_baud_code};
    assign want_frame_ext = {4'd0, cfg.want_frame_code};

    assign fetch_size = (item.send_available > MAX_TX) ? MAX_TX[TXW-1:0]
                                                       : item.send_available[TXW-1:0];
    assign wr_success = (item.write_result == sgth_pkg::WRES_SUCCESS);
    assign wr_error   = (item.write_result == sgth_pkg::WRES_ERROR);

    always_comb begin
        phase_next         = phase_reg;
        tx_req_toggle_next = tx_req_toggle_reg;
        tx_ack_seen_next   = tx_ack_seen_reg;
        rx_req_seen_next   = rx_req_seen_reg;
        rx_ack_toggle_next = rx_ack_toggle_reg;
        control_next       = control_reg;
        tx_size_next       = tx_size_reg;
        cur_handshake_next = cur_handshake_reg;
        cur_baud_next      = cur_baud_reg;
        cur_frame_next     = cur_frame_reg;
        error_flag_next    = error_flag_reg;
        taken              = '0;
        deliver            = 1'b0;
        deliver_cnt        = 8'd0;
        pwrite             = 1'b0;
        ptarget            = sgth_pkg::TGT_HANDSHAKE;
        pvalue             = 8'd0;

        unique case (phase_reg)
            PH_READY: begin
                // Unless a write has failed, pending settings are brought in line before any data moves.
                if (!error_flag_reg && want_hs_ext != cur_handshake_reg) begin
                    pwrite     = 1'b1;
                    ptarget    = sgth_pkg::TGT_HANDSHAKE;
                    pvalue     = want_hs_ext;
                    phase_next = PH_WR_HS;
                end else if (!error_flag_reg && want_baud_ext != cur_baud_reg) begin
                    pwrite     = 1'b1;
                    ptarget    = sgth_pkg::TGT_BAUD;
                    pvalue     = want_baud_ext;
                    phase_next = PH_WR_BAUD;
                end else if (!error_flag_reg && want_frame_ext != cur_frame_reg) begin
                    pwrite     = 1'b1;
                    ptarget    = sgth_pkg::TGT_FRAME;
                    pvalue     = want_frame_ext;
                    phase_next = PH_WR_FRAME;
                end else begin
                    if (item.tx_ack_bit != tx_ack_seen_reg) begin
                        tx_size_next = fetch_size;
                        taken        = fetch_size;
                        if (fetch_size != '0) begin
                            tx_req_toggle_next = !tx_req_toggle_reg;
                            tx_ack_seen_next   = item.tx_ack_bit;
                        end
                    end
                    if (item.rx_req_bit != rx_req_seen_reg) begin
                        rx_req_seen_next   = item.rx_req_bit;
                        deliver            = 1'b1;
                        deliver_cnt        = item.rx_byte_count;
                        rx_ack_toggle_next = !rx_ack_toggle_reg;
                    end
                    control_next = {{(8 - TXW){1'b0}}, tx_size_next, 6'd0,
                                    rx_ack_toggle_next, tx_req_toggle_next};
                end
            end
            PH_INIT_WAIT: begin
                if (!item.init_ack_bit) begin
                    tx_ack_seen_next = 1'b1;
                    control_next     = sgth_pkg::CTRL_CLEAR;
                    phase_next       = PH_READY;
                end
            end
            PH_WR_HS, PH_WR_BAUD, PH_WR_FRAME: begin
                if (wr_success || wr_error) begin
                    phase_next = PH_INIT_REQ;
                end
                if (wr_error) begin
                    error_flag_next = 1'b1;
                end
                if (wr_success) begin
                    if (phase_reg == PH_WR_HS) begin
                        cur_handshake_next = want_hs_ext;
                    end else if (phase_reg == PH_WR_BAUD) begin
                        cur_baud_next = want_baud_ext;
                    end else begin
                        cur_frame_next = want_frame_ext;
                    end
                end
            end
            default: begin
                // Init request, also taken by codes that carry no phase.
                if (item.init_ack_bit) begin
                    control_next = sgth_pkg::CTRL_CLEAR;
                    phase_next   = PH_INIT_WAIT;
                end else begin
                    control_next = sgth_pkg::CTRL_INIT_REQ;
                    phase_next   = PH_INIT_REQ;
                end
            end
        endcase
    end

    always_comb begin
        result.control_word     = control_next;
        result.tx_copy_count    = tx_size_next;
        result.send_taken       = taken;
        result.rx_deliver       = deliver;
        result.rx_deliver_count = deliver_cnt;
        result.param_write      = pwrite;
        result.param_target     = ptarget;
        result.param_value      = pvalue;
        result.port_phase       = phase_next;
        result.setup_failed     = error_flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_INIT_REQ;
            tx_req_toggle_reg <= 1'b0;
            tx_ack_seen_reg   <= 1'b0;
            rx_req_seen_reg   <= 1'b0;
            rx_ack_toggle_reg <= 1'b0;
            control_reg       <= sgth_pkg::CTRL_CLEAR;
            tx_size_reg       <= '0;
            cur_handshake_reg <= sgth_pkg::RST_CUR_HANDSHAKE;
            cur_baud_reg      <= 8'd0;
            cur_frame_reg     <= 8'd0;
            error_flag_reg    <= 1'b0;
        end else if (advance) begin
            phase_reg         <= phase_next;
            tx_req_toggle_reg <= tx_req_toggle_next;
            tx_ack_seen_reg   <= tx_ack_seen_next;
            rx_req_seen_reg   <= rx_req_seen_next;
            rx_ack_toggle_reg <= rx_ack_toggle_next;
            control_reg       <= control_next;
            tx_size_reg       <= tx_size_next;
            cur_handshake_reg <= cur_handshake_next;
            cur_baud_reg      <= cur_baud_next;
            cur_frame_reg     <= cur_frame_next;
            error_flag_reg    <= error_flag_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sgth_out_stage.sv =====
// Result register of the serial gateway toggle handshake block: packs a result into m_tdata.
// Depends on sgth_pkg for the result type and the tdata width.
`default_nettype none

module sgth_out_stage (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           load,
    input  wire sgth_pkg::result_t              result,
    output      logic                           free,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [sgth_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                           valid_reg;
    logic [sgth_pkg::M_TDATA_W-1:0] data_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {6'd0,
                         result.setup_failed,
                         result.port_phase,
                         result.param_value,
                         result.param_target,
                         result.param_write,
                         result.rx_deliver_count,
                         result.rx_deliver,
                         result.send_taken,
                         result.tx_copy_count,
                         result.control_word};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sgth_checker.sv =====
// Port-level checker for the serial gateway toggle handshake block, bound to the top level.
// Depends on sgth_pkg for field widths and the send size limit.
`default_nettype none

module sgth_port_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [sgth_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam logic [4:0] MAX_TX = 5'(sgth_pkg::MAX_TX_BYTES);

    // A stalled result transaction keeps its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The input side only waits behind a stalled result.
    a_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled result");

    // Receive and parameter fields are zero unless their strobe is set.
    a_strobes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[26] || m_tdata[34:27] == 8'd0)
                  && (m_tdata[35] || m_tdata[45:36] == 10'd0))
        else $error("strobe-qualified field set without its strobe");

    // Send sizes never pass the limit and the phase code stays in range.
    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[20:16] <= MAX_TX && m_tdata[25:21] <= MAX_TX
                  && m_tdata[48:46] <= 3'd5)
        else $error("result field out of range");

endmodule

bind serial_gateway_toggle_handshake sgth_port_checker u_sgth_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== dv/sgth_checker.sv =====
// Scoreboard for the serial gateway toggle handshake block: watches the input, result and
// configuration channels, predicts each port cycle and compares the results field by field.
// Depends on sgth_pkg for the item and configuration layouts.
module sgth_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [sgth_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [sgth_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [sgth_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgth_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import sgth_pkg::*;

    localparam logic [TX_SIZE_W-1:0] TX_CAP = TX_SIZE_W'(MAX_TX_BYTES);

    typedef enum logic [2:0] {
        PH_INIT_REQ     = 3'd0,
        PH_INIT_WAIT    = 3'd1,
        PH_READY        = 3'd2,
        PH_WR_HANDSHAKE = 3'd3,
        PH_WR_BAUD      = 3'd4,
        PH_WR_FRAME     = 3'd5
    } port_phase_e;

    // Mirror of the port machine and of the requested settings.
    cfg_t                 port_req;
    port_phase_e          port_phase_q;
    logic                 tx_req_toggle;
    logic                 tx_ack_seen;
    logic                 rx_req_seen;
    logic                 rx_ack_toggle;
    logic                 write_failed;
    logic [15:0]          control_q;
    logic [TX_SIZE_W-1:0] tx_size_q;
    logic [7:0]           cur_handshake;
    logic [7:0]           cur_baud;
    logic [7:0]           cur_frame;

    result_t predicted_outcomes[$];
    int      result_count;

    initial begin
        fail_count   = 0;
        outstanding  = 0;
        result_count = 0;
    end

    task automatic report_mismatch(string msg);
        $display("%0t ns checker: result %0d: %s", $time, result_count, msg);
        fail_count++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task automatic reset_port();
        port_req.want_handshake  = RST_WANT_HANDSHAKE;
        port_req.want_baud_code  = RST_WANT_BAUD;
        port_req.want_frame_code = RST_WANT_FRAME;
        port_phase_q   = PH_INIT_REQ;
        tx_req_toggle  = 1'b0;
        tx_ack_seen    = 1'b0;
        rx_req_seen    = 1'b0;
        rx_ack_toggle  = 1'b0;
        write_failed   = 1'b0;
        control_q      = CTRL_CLEAR;
        tx_size_q      = '0;
        cur_handshake  = RST_CUR_HANDSHAKE;
        cur_baud       = '0;
        cur_frame      = '0;
    endtask

    function automatic in_item_t unpack_cycle(logic [S_TDATA_W-1:0] d);
        in_item_t it;
        it.tx_ack_bit     = d[0];
        it.rx_req_bit     = d[1];
        it.init_ack_bit   = d[2];
        it.rx_byte_count  = d[10:3];
        it.send_available = d[18:11];
        it.write_result   = d[20:19];
        return it;
    endfunction

    function automatic result_t unpack_outcome(logic [M_TDATA_W-1:0] d);
        result_t r;
        r.control_word     = d[15:0];
        r.tx_copy_count    = d[20:16];
        r.send_taken       = d[25:21];
        r.rx_deliver       = d[26];
        r.rx_deliver_count = d[34:27];
        r.param_write      = d[35];
        r.param_target     = d[37:36];
        r.param_value      = d[45:38];
        r.port_phase       = d[48:46];
        r.setup_failed     = d[49];
        return r;
    endfunction

    // A pending write ends on success or error; busy and the unused code keep waiting.
    function automatic logic [7:0] settle_write(logic [1:0] wres, logic [7:0] cur,
                                                logic [7:0] want);
        if (wres == WRES_SUCCESS) begin
            port_phase_q = PH_INIT_REQ;
            return want;
        end
        if (wres == WRES_ERROR) begin
            port_phase_q = PH_INIT_REQ;
            write_failed = 1'b1;
        end
        return cur;
    endfunction

    function automatic result_t next_port_cycle(in_item_t it);
        result_t              r;
        logic [TX_SIZE_W-1:0] fetched;
        r       = '0;
        fetched = '0;
        case (port_phase_q)
            PH_READY: begin
                if (!write_failed && {7'b0, port_req.want_handshake} != cur_handshake) begin
                    r.param_write  = 1'b1;
                    r.param_target = TGT_HANDSHAKE;
                    r.param_value  = {7'b0, port_req.want_handshake};
                    port_phase_q   = PH_WR_HANDSHAKE;
                end else if (!write_failed && {4'b0, port_req.want_baud_code} != cur_baud) begin
                    r.param_write  = 1'b1;
                    r.param_target = TGT_BAUD;
                    r.param_value  = {4'b0, port_req.want_baud_code};
                    port_phase_q   = PH_WR_BAUD;
                end else if (!write_failed &&
                             {4'b0, port_req.want_frame_code} != cur_frame) begin
                    r.param_write  = 1'b1;
                    r.param_target = TGT_FRAME;
                    r.param_value  = {4'b0, port_req.want_frame_code};
                    port_phase_q   = PH_WR_FRAME;
                end else begin
                    if (it.tx_ack_bit != tx_ack_seen) begin
                        tx_size_q = (it.send_available > 8'(MAX_TX_BYTES)) ? TX_CAP :
                                    it.send_available[TX_SIZE_W-1:0];
                        fetched   = tx_size_q;
                        // An empty fetch leaves both send toggles where they are.
                        if (tx_size_q != '0) begin
                            tx_req_toggle = ~tx_req_toggle;
                            tx_ack_seen   = it.tx_ack_bit;
                        end
                    end
                    if (it.rx_req_bit != rx_req_seen) begin
                        rx_req_seen        = it.rx_req_bit;
                        r.rx_deliver       = 1'b1;
                        r.rx_deliver_count = it.rx_byte_count;
                        rx_ack_toggle      = ~rx_ack_toggle;
                    end
                    control_q = {3'b0, tx_size_q, 6'b0, rx_ack_toggle, tx_req_toggle};
                end
            end
            PH_INIT_WAIT: begin
                if (!it.init_ack_bit) begin
                    tx_ack_seen  = 1'b1;
                    control_q    = CTRL_CLEAR;
                    port_phase_q = PH_READY;
                end
            end
            PH_WR_HANDSHAKE: cur_handshake = settle_write(it.write_result, cur_handshake,
                                                          {7'b0, port_req.want_handshake});
            PH_WR_BAUD:      cur_baud = settle_write(it.write_result, cur_baud,
                                                     {4'b0, port_req.want_baud_code});
            PH_WR_FRAME:     cur_frame = settle_write(it.write_result, cur_frame,
                                                      {4'b0, port_req.want_frame_code});
            default: begin
                if (it.init_ack_bit) begin
                    control_q    = CTRL_CLEAR;
                    port_phase_q = PH_INIT_WAIT;
                end else begin
                    control_q    = CTRL_INIT_REQ;
                    port_phase_q = PH_INIT_REQ;
                end
            end
        endcase
        r.control_word  = control_q;
        r.tx_copy_count = tx_size_q;
        r.send_taken    = fetched;
        r.port_phase    = port_phase_q;
        r.setup_failed  = write_failed;
        return r;
    endfunction

    task automatic compare_outcome(result_t got, result_t want);
        check_field("control_word", 64'(got.control_word), 64'(want.control_word));
        check_field("tx_copy_count", 64'(got.tx_copy_count), 64'(want.tx_copy_count));
        check_field("send_taken", 64'(got.send_taken), 64'(want.send_taken));
        check_field("rx_deliver", 64'(got.rx_deliver), 64'(want.rx_deliver));
        check_field("rx_deliver_count", 64'(got.rx_deliver_count),
                    64'(want.rx_deliver_count));
        check_field("param_write", 64'(got.param_write), 64'(want.param_write));
        check_field("param_target", 64'(got.param_target), 64'(want.param_target));
        check_field("param_value", 64'(got.param_value), 64'(want.param_value));
        check_field("port_phase", 64'(got.port_phase), 64'(want.port_phase));
        check_field("setup_failed", 64'(got.setup_failed), 64'(want.setup_failed));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_port();
            predicted_outcomes.delete();
        end else begin
            // Results are checked before this edge's input is predicted, so a result
            // can never be matched against its own input in the same cycle.
            if (m_tvalid && m_tready) begin
                if (predicted_outcomes.size() == 0)
                    report_mismatch("result transaction with no expectation waiting");
                else
                    compare_outcome(unpack_outcome(m_tdata), predicted_outcomes.pop_front());
                result_count++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IDX_HANDSHAKE: port_req.want_handshake  = cfg_data[0];
                    CFG_IDX_BAUD:      port_req.want_baud_code  = cfg_data;
                    CFG_IDX_FRAME:     port_req.want_frame_code = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predicted_outcomes.push_back(next_port_cycle(unpack_cycle(s_tdata)));
        end
        outstanding = predicted_outcomes.size();
    end

endmodule

// ===== dv/tb.sv =====
// Top of the testbench for the serial gateway toggle handshake block: clock, reset,
// directed and random port cycles, configuration phases and the final verdict.
// Depends on sgth_pkg, the block's RTL and sgth_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sgth_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int DRAIN_CYCLES    = 4;

    localparam logic [1:0]           WRES_BUSY     = 2'd0;
    localparam logic [1:0]           WRES_UNKNOWN  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          fail_count;
    int          outstanding;
    int unsigned cycle_count    = 0;

    serial_gateway_toggle_handshake i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sgth_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_cycle(logic tx_ack, logic rx_req,
                                                        logic init_ack, logic [7:0] rx_cnt,
                                                        logic [7:0] avail, logic [1:0] wres);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[20:0] = {wres, avail, rx_cnt, init_ack, rx_req, tx_ack};
        return d;
    endfunction

    // Mostly successful writes with some busy and unknown codes; errors are sticky until reset,
    // so they are only allowed in the last phase.
    function automatic logic [S_TDATA_W-1:0] random_cycle(bit allow_error);
        int         pick;
        logic [7:0] avail;
        logic [1:0] wres;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       avail = 8'd0;
            1:       avail = 8'd255;
            2:       avail = 8'($urandom_range(21, 23));
            3:       avail = 8'($urandom_range(0, 255));
            default: avail = 8'($urandom_range(1, 30));
        endcase
        pick = $urandom_range(0, 99);
        if (allow_error && pick < 5)
            wres = WRES_ERROR;
        else if (pick < 30)
            wres = WRES_BUSY;
        else if (pick < 40)
            wres = WRES_UNKNOWN;
        else
            wres = WRES_SUCCESS;
        return pack_cycle(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), avail, wres);
    endfunction

    task automatic push_port_cycle(logic [S_TDATA_W-1:0] d);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Registers change only with no transaction in flight.
    task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic start_phase(int p);
        logic       hs;
        logic [3:0] baud;
        logic [3:0] frame;
        case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
        case (p)
            0: begin hs = 1'b1; baud = 4'd10; frame = 4'd13; end
            1: begin hs = 1'b0; baud = 4'd1;  frame = 4'd1;  end
            2: begin hs = 1'b1; baud = 4'd0;  frame = 4'd0;  end
            3: begin hs = 1'b0; baud = 4'd15; frame = 4'd15; end
            6: begin hs = 1'b0; baud = 4'd6;  frame = 4'd3;  end
            default: begin
                hs    = 1'($urandom_range(0, 1));
                baud  = 4'($urandom_range(0, 15));
                frame = 4'($urandom_range(0, 15));
            end
        endcase
        // Upper data bits of the handshake register are ignored by the block.
        write_setting(CFG_IDX_HANDSHAKE, {3'($urandom_range(0, 7)), hs});
        write_setting(CFG_IDX_BAUD, baud);
        write_setting(CFG_IDX_FRAME, frame);
        if (p == 0)
            write_setting(CFG_IDX_SPARE, 4'($urandom_range(0, 15)));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Walk the port through init, all three parameter writes and then ready,
        // with the default settings.
        push_port_cycle(pack_cycle(1'b1, 1'b1, 1'b0, 8'd255, 8'd255, WRES_UNKNOWN));
        push_port_cycle(pack_cycle(1'b0, 1'b0, 1'b1, 8'd0, 8'd0, WRES_BUSY));
        push_port_cycle(pack_cycle(1'b0, 1'b0, 1'b1, 8'd0, 8'd0, WRES_BUSY));
        push_port_cycle(pack_cycle(1'b0, 1'b0, 1'b0, 8'd0, 8'd0, WRES_BUSY));
        push_port_cycle(pack_cycle(1'b0, 1'b1, 1'b0, 8'd7, 8'd9, WRES_ERROR));
        push_port_cycle(pack_cycle(1'b0, 1'b0, 1'b0, 8'd0, 8'd0, WRES_BUSY));
        push_port_cycle(pack_cycle(1'b0, 1'b0, 1'b0, 8'd0, 8'd0, WRES_UNKNOWN));
        push_port_cycle(pack_cycle(1'b0, 1'b0, 1'b0, 8'd0, 8'd0, WRES_SUCCESS));
        push_port_cycle(pack_cycle(1'b0, 1'b0, 1'b1, 8'd0, 8'd0, WRES_BUSY));
        push_port_cycle(pack_cycle(1'b0, 1'b0, 1'b0, 8'd0, 8'd0, WRES_BUSY));
        push_port_cycle(pack_cycle(1'b1, 1'b1, 1'b0, 8'd3, 8'd3, WRES_ERROR));
        push_port_cycle(pack_cycle(1'b0, 1'b0, 1'b0, 8'd0, 8'd0, WRES_SUCCESS));
        push_port_cycle(pack_cycle(1'b0, 1'b0, 1'b1, 8'd0, 8'd0, WRES_BUSY));
        push_port_cycle(pack_cycle(1'b0, 1'b0, 1'b0, 8'd0, 8'd0, WRES_BUSY));
        push_port_cycle(pack_cycle(1'b0, 1'b0, 1'b0, 8'd0, 8'd0, WRES_BUSY));
        push_port_cycle(pack_cycle(1'b0, 1'b0, 1'b0, 8'd0, 8'd0, WRES_SUCCESS));
        push_port_cycle(pack_cycle(1'b0, 1'b0, 1'b1, 8'd0, 8'd0, WRES_BUSY));
        push_port_cycle(pack_cycle(1'b0, 1'b0, 1'b0, 8'd0, 8'd0, WRES_BUSY));
        // Ready: an empty fetch, a saturated fetch, the exact cap, receive deliveries.
        push_port_cycle(pack_cycle(1'b0, 1'b1, 1'b0, 8'd255, 8'd0, WRES_BUSY));
        push_port_cycle(pack_cycle(1'b0, 1'b1, 1'b0, 8'd0, 8'd255, WRES_ERROR));
        push_port_cycle(pack_cycle(1'b1, 1'b0, 1'b0, 8'd0, 8'd22, WRES_BUSY));
        push_port_cycle(pack_cycle(1'b0, 1'b1, 1'b1, 8'd128, 8'd21, WRES_SUCCESS));
        push_port_cycle(pack_cycle(1'b0, 1'b1, 1'b0, 8'd1, 8'd5, WRES_BUSY));

        for (int p = 0; p < PHASE_COUNT; p++) begin
            start_phase(p);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                push_port_cycle(random_cycle(p == PHASE_COUNT - 1));
        end

        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
